// ===== sv/modbus_read_coils_responder_defines.svh =====
// Assertion macros used by the checker of the read-coils responder.
`ifndef MODBUS_READ_COILS_RESPONDER_DEFINES_SVH
`define MODBUS_READ_COILS_RESPONDER_DEFINES_SVH

// Same-cycle implication, sampled on clk and idle while rst_n is low.
`define MRC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and idle while rst_n is low.
`define MRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/mrc_pkg.sv =====
`default_nettype none

package mrc_pkg;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_WB,
    ST_CHECK,
    ST_LOAD,
    ST_HDR,
    ST_EXC,
    ST_DATA
  } mrc_state_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [1:0] CFG_BASE  = 2'd0;
  localparam logic [1:0] CFG_COUNT = 2'd1;

  localparam logic [7:0] EXC_NONE = 8'h00;
  localparam logic [7:0] EXC_ADDR = 8'h02;
  localparam logic [7:0] EXC_QTY  = 8'h03;

  localparam int          PTR_W       = 17;
  localparam int          ROW_W       = 64;
  localparam logic [15:0] MAX_QTY     = 16'd2040;
  localparam logic [8:0]  HDR_BYTES   = 9'd9;
  localparam logic [15:0] PDU_EXTRA   = 16'd3;
  localparam logic [8:0]  WORD_BYTES  = 9'd8;
  localparam logic [6:0]  FIRST_COILS = 7'd56;
  localparam logic [6:0]  WORD_COILS  = 7'd64;

endpackage

`default_nettype wire

// ===== sv/modbus_read_coils_responder.sv =====
// Write item: ST_IDLE accepts it and reads the coil row, ST_WR_WB writes the row back.
// Request: ST_CHECK checks the window and ST_LOAD loads the first row (skipped for an exception);
// ST_HDR then presents the header word, and the reply words follow one word per cycle while
// out_stall is low. in_stall stays high until the last reply word is in the output register.
// Reset (synchronous, rst_n low) clears state, out_valid, base and count, then zeros are swept
// through all 2**RAW coil store rows, one per cycle (64 at default), with in_stall held high.
`default_nettype none

module modbus_read_coils_responder #(
  parameter int COILS = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_operation,
  input  wire logic [11:0] in_coil_index,
  input  wire logic        in_coil_value,
  input  wire logic [15:0] in_transaction_id,
  input  wire logic [15:0] in_protocol_id,
  input  wire logic [7:0]  in_unit_id,
  input  wire logic [6:0]  in_function_code,
  input  wire logic [15:0] in_start_address,
  input  wire logic [15:0] in_quantity,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_word,
  output logic [3:0]       out_bytes,
  output logic             out_last,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import mrc_pkg::*;

  localparam int ROWS_USED = (COILS + ROW_W - 1) / ROW_W;
  localparam int RAW       = (ROWS_USED > 1) ? $clog2(ROWS_USED) : 1;
  localparam int ROWS      = 1 << RAW;

  mrc_state_t state_r, state_nxt;

  logic [RAW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [15:0]      base_r;
  logic [12:0]      count_r;
  logic             out_valid_r, out_valid_nxt;
  logic [63:0]      out_word_r, out_word_nxt;
  logic [3:0]       out_bytes_r, out_bytes_nxt;
  logic             out_last_r, out_last_nxt;

  logic [11:0]      coil_idx_r;
  logic             coil_val_r;
  logic [15:0]      tid_r, pid_r, start_r, qty_r;
  logic [7:0]       unit_r;
  logic [6:0]       func_r;
  logic [7:0]       code_r, code_nxt;
  logic [7:0]       nbytes_r, nbytes_nxt;
  logic [8:0]       blft_r, blft_nxt;
  logic [10:0]      rem_r, rem_nxt;
  logic [PTR_W-1:0] ptr_r, ptr_nxt;
  logic [63:0]      cur_r, cur_nxt;
  logic             first_r, first_nxt;

  logic [ROW_W-1:0] mem [ROWS];
  logic [ROW_W-1:0] rd_data_r;
  logic             mem_we;
  logic [RAW-1:0]   mem_waddr, mem_raddr;
  logic [ROW_W-1:0] mem_wdata;

  logic             ld;
  logic             wr_in_range;
  logic [PTR_W-1:0] count_sat, lim, top;
  logic [15:0]      off;
  logic [16:0]      qty_round;
  logic [127:0]     win128;
  logic [63:0]      coil_mask, coil_bits, swapped;
  logic [6:0]       step;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_bytes = out_bytes_r;
  assign out_last  = out_last_r;

  // The output register can take a new word when it is empty or being transferred.
  assign ld = !out_valid_r || !out_stall;

  assign wr_in_range = PTR_W'(in_coil_index) < PTR_W'(COILS);

  // Window check, all sums widened so that nothing wraps.
  assign count_sat = (PTR_W'(count_r) > PTR_W'(COILS)) ? PTR_W'(COILS) : PTR_W'(count_r);
  assign lim       = PTR_W'(base_r) + count_sat;
  assign top       = PTR_W'(start_r) + PTR_W'(qty_r);
  assign off       = start_r - base_r;
  assign qty_round = 17'(qty_r) + 17'd7;

  // rd_data_r always holds the row after the one in cur_r while a reply is streamed.
  assign win128    = {rd_data_r, cur_r} >> ptr_r[5:0];
  assign coil_mask = (rem_r >= 11'(WORD_COILS)) ? {64{1'b1}} : ~({64{1'b1}} << rem_r[5:0]);
  assign coil_bits = win128[63:0] & coil_mask;
  assign step      = first_r ? FIRST_COILS : WORD_COILS;

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      swapped[63 - 8 * b -: 8] = coil_bits[8 * b +: 8];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == RAW'(ROWS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_operation == OP_READ) state_nxt = ST_CHECK;
          else if (wr_in_range) state_nxt = ST_WR_WB;
        end
      end
      ST_WR_WB: state_nxt = ST_IDLE;
      ST_CHECK: state_nxt = (code_nxt != EXC_NONE) ? ST_HDR : ST_LOAD;
      ST_LOAD:  state_nxt = ST_HDR;
      ST_HDR: begin
        if (ld) state_nxt = (code_r != EXC_NONE) ? ST_EXC : ST_DATA;
      end
      ST_EXC: begin
        if (ld) state_nxt = ST_IDLE;
      end
      ST_DATA: begin
        if (ld && blft_r <= WORD_BYTES) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    out_bytes_nxt = out_bytes_r;
    out_last_nxt  = out_last_r;
    code_nxt      = code_r;
    nbytes_nxt    = nbytes_r;
    blft_nxt      = blft_r;
    rem_nxt       = rem_r;
    ptr_nxt       = ptr_r;
    cur_nxt       = cur_r;
    first_nxt     = first_r;
    mem_we        = 1'b0;
    mem_waddr     = RAW'(coil_idx_r >> 6);
    mem_wdata     = rd_data_r;
    mem_raddr     = RAW'(ptr_r[PTR_W-1:6] + 11'd1);

    unique case (state_r)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_cnt_r;
        mem_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + RAW'(1);
      end
      ST_IDLE: begin
        mem_raddr = RAW'(in_coil_index >> 6);
      end
      ST_WR_WB: begin
        mem_we                       = 1'b1;
        mem_wdata[coil_idx_r[5:0]]   = coil_val_r;
      end
      ST_CHECK: begin
        if (start_r < base_r || top > lim || qty_r > MAX_QTY) code_nxt = EXC_ADDR;
        else if (qty_r == 16'd0) code_nxt = EXC_QTY;
        else code_nxt = EXC_NONE;
        nbytes_nxt = qty_round[10:3];
        blft_nxt   = (code_nxt != EXC_NONE) ? HDR_BYTES : HDR_BYTES + 9'(nbytes_nxt);
        rem_nxt    = qty_r[10:0];
        ptr_nxt    = PTR_W'(off);
        first_nxt  = 1'b1;
        mem_raddr  = RAW'(off >> 6);
      end
      ST_LOAD: begin
        cur_nxt = rd_data_r;
      end
      ST_HDR: begin
        if (ld) begin
          out_valid_nxt = 1'b1;
          if (code_r != EXC_NONE) begin
            out_word_nxt = {tid_r, pid_r, PDU_EXTRA, unit_r, 1'b1, func_r};
          end else begin
            out_word_nxt = {tid_r, pid_r, 16'(nbytes_r) + PDU_EXTRA, unit_r, 1'b0, func_r};
          end
          out_bytes_nxt = 4'd8;
          out_last_nxt  = 1'b0;
          blft_nxt      = blft_r - WORD_BYTES;
        end
      end
      ST_EXC: begin
        if (ld) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = {code_r, 56'd0};
          out_bytes_nxt = 4'd1;
          out_last_nxt  = 1'b1;
        end
      end
      ST_DATA: begin
        if (ld) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = first_r ? {nbytes_r, swapped[63:8]} : swapped;
          out_bytes_nxt = (blft_r >= WORD_BYTES) ? 4'd8 : blft_r[3:0];
          out_last_nxt  = (blft_r <= WORD_BYTES);
          blft_nxt      = blft_r - WORD_BYTES;
          rem_nxt       = (rem_r > 11'(step)) ? rem_r - 11'(step) : '0;
          ptr_nxt       = ptr_r + PTR_W'(step);
          first_nxt     = 1'b0;
          // The window moves at most one row per word, so the prefetched row becomes current.
          if (ptr_nxt[PTR_W-1:6] != ptr_r[PTR_W-1:6]) cur_nxt = rd_data_r;
          mem_raddr = RAW'(ptr_nxt[PTR_W-1:6] + 11'd1);
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      base_r      <= '0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BASE:  base_r  <= cfg_data;
          CFG_COUNT: count_r <= cfg_data[12:0];
          default:   base_r  <= base_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      coil_idx_r <= in_coil_index;
      coil_val_r <= in_coil_value;
      tid_r      <= in_transaction_id;
      pid_r      <= in_protocol_id;
      unit_r     <= in_unit_id;
      func_r     <= in_function_code;
      start_r    <= in_start_address;
      qty_r      <= in_quantity;
    end
    out_word_r  <= out_word_nxt;
    out_bytes_r <= out_bytes_nxt;
    out_last_r  <= out_last_nxt;
    code_r      <= code_nxt;
    nbytes_r    <= nbytes_nxt;
    blft_r      <= blft_nxt;
    rem_r       <= rem_nxt;
    ptr_r       <= ptr_nxt;
    cur_r       <= cur_nxt;
    first_r     <= first_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/mrc_checker.sv =====
`default_nettype none
`include "modbus_read_coils_responder_defines.svh"

module mrc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [63:0] out_word,
  input wire logic [3:0]  out_bytes,
  input wire logic        out_last
);

  `MRC_ASSERT_IMP(a_bytes_range, out_valid, out_bytes != 4'd0 && out_bytes <= 4'd8, "out_bytes outside 1 to 8")

  `MRC_ASSERT_IMP(a_full_unless_last, out_valid && !out_last, out_bytes == 4'd8, "short word before the end of a reply")

  `MRC_ASSERT_IMP(a_single_byte_pad, out_valid && out_bytes == 4'd1, out_word[55:0] == 56'd0, "unused bytes of a one-byte word are not zero")

  // While a reply is only partly delivered, no new item may be taken.
  `MRC_ASSERT_IMP(a_busy_mid_reply, out_valid && !out_last, in_stall, "input open in the middle of a reply")

  `MRC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word), "stalled reply word changed")

endmodule

bind modbus_read_coils_responder mrc_checker u_mrc_checker (.*);

`default_nettype wire
